>>> src/bfc_pkg.sv
// bfc_pkg: shared types and constants of the byte-stuffing frame codec
// no dependencies; imported by every module of the block

package bfc_pkg;

    // flag and escape bytes on the line
    localparam logic [7:0] FLAG_START = 8'hFE;
    localparam logic [7:0] FLAG_END   = 8'hEF;
    localparam logic [7:0] ESC        = 8'hFD;
    localparam logic [7:0] ESC_START  = 8'h01;
    localparam logic [7:0] ESC_END    = 8'hF2;
    localparam logic [7:0] ESC_ESC    = 8'h00;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // results one input beat can cause, and the job queue depth
    localparam int MAX_RES     = 4;
    localparam int SLOT_W      = $clog2(MAX_RES);
    localparam int CNT_W       = $clog2(MAX_RES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last_of_run;
    } t_out;

    // one result waiting in a job
    typedef struct packed {
        logic [7:0] res_byte;
        logic [1:0] kind;
    } t_slot;

    // all results of one input beat
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        t_slot [MAX_RES-1:0]     slot;
    } t_job;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

>>> src/bfc_front.sv
// bfc_front: accepts input beats, holds direction and decode phase, builds result jobs
// depends on bfc_pkg

module bfc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_data,
    input  logic          i_in_valid,
    input  bfc_pkg::t_in  i_in_data,
    input  bfc_pkg::t_qstat i_qstat,
    output logic          o_in_stall,
    output logic          o_push,
    output bfc_pkg::t_job o_job
);
    import bfc_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_FRAME   = 2'd1,
        PH_ESCAPED = 2'd2
    } t_phase;

    logic   r_dir;
    t_phase r_phase;
    t_phase n_phase;
    logic   w_accept;
    t_job   w_job;

    assign o_in_stall = i_qstat.full;
    assign w_accept   = i_in_valid && !i_qstat.full;
    assign o_push     = w_accept && (w_job.count != '0);
    assign o_job      = w_job;

    // classify the beat and list the results it causes
    always_comb begin
        logic [CNT_W-1:0] v_cnt;
        logic [7:0]       v_b;
        v_cnt   = '0;
        v_b     = i_in_data.in_byte;
        w_job   = '0;
        n_phase = r_phase;
        if (r_dir == DIR_ENCODE) begin
            if (i_in_data.first_byte) begin
                w_job.slot[v_cnt[SLOT_W-1:0]] = '{FLAG_START, KIND_DATA};
                v_cnt = v_cnt + 1'b1;
            end
            if (v_b == FLAG_START || v_b == FLAG_END || v_b == ESC) begin
                w_job.slot[v_cnt[SLOT_W-1:0]] = '{ESC, KIND_DATA};
                v_cnt = v_cnt + 1'b1;
                if (v_b == FLAG_START) begin
                    w_job.slot[v_cnt[SLOT_W-1:0]] = '{ESC_START, KIND_DATA};
                end else if (v_b == FLAG_END) begin
                    w_job.slot[v_cnt[SLOT_W-1:0]] = '{ESC_END, KIND_DATA};
                end else begin
                    w_job.slot[v_cnt[SLOT_W-1:0]] = '{ESC_ESC, KIND_DATA};
                end
                v_cnt = v_cnt + 1'b1;
            end else begin
                w_job.slot[v_cnt[SLOT_W-1:0]] = '{v_b, KIND_DATA};
                v_cnt = v_cnt + 1'b1;
            end
            if (i_in_data.last_byte) begin
                w_job.slot[v_cnt[SLOT_W-1:0]] = '{FLAG_END, KIND_DATA};
                v_cnt = v_cnt + 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_FRAME: begin
                    if (v_b == FLAG_END) begin
                        w_job.slot[v_cnt[SLOT_W-1:0]] = '{8'h00, KIND_DONE};
                        v_cnt   = v_cnt + 1'b1;
                        n_phase = PH_HUNT;
                    end else if (v_b == ESC) begin
                        n_phase = PH_ESCAPED;
                    end else begin
                        w_job.slot[v_cnt[SLOT_W-1:0]] = '{v_b, KIND_DATA};
                        v_cnt = v_cnt + 1'b1;
                    end
                end
                PH_ESCAPED: begin
                    if (v_b == ESC_START) begin
                        w_job.slot[v_cnt[SLOT_W-1:0]] = '{FLAG_START, KIND_DATA};
                        n_phase = PH_FRAME;
                    end else if (v_b == ESC_ESC) begin
                        w_job.slot[v_cnt[SLOT_W-1:0]] = '{ESC, KIND_DATA};
                        n_phase = PH_FRAME;
                    end else if (v_b == ESC_END) begin
                        w_job.slot[v_cnt[SLOT_W-1:0]] = '{FLAG_END, KIND_DATA};
                        n_phase = PH_FRAME;
                    end else begin
                        w_job.slot[v_cnt[SLOT_W-1:0]] = '{8'h00, KIND_ERR};
                        n_phase = PH_HUNT;
                    end
                    v_cnt = v_cnt + 1'b1;
                end
                default: begin
                    n_phase = (v_b == FLAG_START) ? PH_FRAME : PH_HUNT;
                end
            endcase
            // buffer end with a frame still open
            if (i_in_data.last_byte && n_phase != PH_HUNT) begin
                w_job.slot[v_cnt[SLOT_W-1:0]] = '{8'h00, KIND_ERR};
                v_cnt   = v_cnt + 1'b1;
                n_phase = PH_HUNT;
            end
        end
        w_job.count = v_cnt;
    end

    // direction register and decode phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_phase <= PH_HUNT;
        end else if (i_cfg_valid) begin
            r_dir   <= i_cfg_data;
            r_phase <= PH_HUNT;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

>>> src/bfc_queue.sv
// bfc_queue: short register queue of result jobs between front and back end
// depends on bfc_pkg

module bfc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bfc_pkg::t_job   i_job,
    input  logic            i_pop,
    output bfc_pkg::t_job   o_head,
    output bfc_pkg::t_qstat o_qstat
);
    import bfc_pkg::*;

    t_job              r_store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_qstat.empty = (r_fill == '0);
    assign o_qstat.full  = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_head        = r_store[r_rd_ptr];
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;

    // job storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_store[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> src/bfc_back.sv
// bfc_back: walks the head job slot by slot into the output register
// depends on bfc_pkg

module bfc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bfc_pkg::t_job   i_head,
    input  bfc_pkg::t_qstat i_qstat,
    input  logic            i_out_stall,
    output logic            o_pop,
    output logic            o_out_valid,
    output bfc_pkg::t_out   o_out_data
);
    import bfc_pkg::*;

    logic [SLOT_W-1:0] r_idx;
    logic              r_valid;
    t_out              r_out;
    logic              w_load;
    logic              w_last;
    t_slot             w_slot;

    assign w_load      = !i_qstat.empty && (!r_valid || !i_out_stall);
    assign w_slot      = i_head.slot[r_idx];
    assign w_last      = (CNT_W'(r_idx) + 1'b1 == i_head.count);
    assign o_pop       = w_load && w_last;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    // slot index within the head job, and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= w_last ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_byte    <= w_slot.res_byte;
            r_out.kind        <= w_slot.kind;
            r_out.last_of_run <= w_last;
        end
    end

endmodule

>>> src/byte_stuffing_frame_codec_top.sv
// Byte-stuffing frame codec. direction 0 escapes bytes (FE -> FD 01, EF -> FD F2,
// FD -> FD 00) and adds an FE flag before a first_byte beat and an EF flag after a
// last_byte beat; direction 1 hunts for FE, unescapes, reports kind 1 on EF and
// kind 2 on a bad escape or a buffer end inside a frame. Each input beat yields 0 to 4
// results; the output port delivers one result per cycle while the receiver does not
// stall, so the output register sets the throughput. The front end takes a beat per
// cycle into a four-job queue while the queue is not full. An input beat's first
// result passes through the queue storage and then the output register. Write direction
// only while idle; a write also restarts the decoder hunting.
// depends on bfc_pkg, bfc_front, bfc_queue, bfc_back

module byte_stuffing_frame_codec_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bfc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bfc_pkg::t_out o_out_data
);
    import bfc_pkg::*;

    logic   w_push;
    logic   w_pop;
    t_job   w_job;
    t_job   w_head;
    t_qstat w_qstat;

    assign o_cfg_ready = 1'b1;

    // front end: accept and classify
    bfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_qstat     (w_qstat),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // job queue
    bfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // back end: emit results
    bfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> src/bfc_checker.sv
// bfc_checker: port-level assertions for the frame codec, bound to the top level
// depends on bfc_pkg and byte_stuffing_frame_codec_top

module bfc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cfg_valid,
    input logic          o_cfg_ready,
    input logic          i_cfg_data,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input bfc_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bfc_pkg::t_out o_out_data
);
    import bfc_pkg::*;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // kind stays within its three codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.kind != 2'd3)
        else $error("unknown result kind");

    // frame done or error carries a zero byte and closes the run
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_DATA
            |-> o_out_data.out_byte == 8'h00 && o_out_data.last_of_run)
        else $error("status result malformed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind byte_stuffing_frame_codec_top bfc_checker u_bfc_checker (.*);

>>> verif/byte_stuffing_frame_codec_top_test.sv
// self-checking testbench for the byte-stuffing frame codec: a directed table, then random frames
// in both directions under four idling patterns; results checked by the table or a local predictor
// depends on bfc_pkg and byte_stuffing_frame_codec_top
`timescale 1ns / 1ps

module byte_stuffing_frame_codec_top_test;
    import bfc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 12;

    typedef enum logic [1:0] {
        HUNTING   = 2'd0,
        IN_FRAME  = 2'd1,
        AFTER_ESC = 2'd2
    } t_phase;

    // results typed in by hand for one beat; count -1 leaves it to the predictor
    typedef struct {
        int         count;
        t_out [3:0] res;
    } t_fixed;

    typedef struct {
        logic       dir;
        t_in        beat;
        int         count;
        t_out [3:0] res;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_ready;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // predictor state, touched only by the checker block
    logic   model_dir = DIR_ENCODE;
    t_phase model_phase = HUNTING;

    t_out   results_due[$];
    t_fixed fixed_due[$];
    t_row   stim_rows[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int mismatches = 0;
    int beats_in = 0;
    int results_seen = 0;
    int dir_writes = 0;

    byte_stuffing_frame_codec_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("byte_stuffing_frame_codec_top_test failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_out mk_out(input logic [7:0] b, input logic [1:0] k, input logic l);
        t_out r;
        r.out_byte = b;
        r.kind = k;
        r.last_of_run = l;
        return r;
    endfunction

    function automatic void add_result(inout t_out [3:0] res, inout int n,
                                       input logic [7:0] b, input logic [1:0] k);
        res[n] = mk_out(b, k, 1'b0);
        n++;
    endfunction

    // stuff/frame or deframe/unstuff one beat, updating the decoder phase
    function automatic void codec_predict(input t_in beat, output t_out [3:0] res,
                                          output int n);
        logic [7:0] b;
        b = beat.in_byte;
        n = 0;
        res = '0;
        if (model_dir == DIR_ENCODE) begin
            if (beat.first_byte) add_result(res, n, FLAG_START, KIND_DATA);
            case (b)
                FLAG_START: begin
                    add_result(res, n, ESC, KIND_DATA);
                    add_result(res, n, ESC_START, KIND_DATA);
                end
                FLAG_END: begin
                    add_result(res, n, ESC, KIND_DATA);
                    add_result(res, n, ESC_END, KIND_DATA);
                end
                ESC: begin
                    add_result(res, n, ESC, KIND_DATA);
                    add_result(res, n, ESC_ESC, KIND_DATA);
                end
                default: add_result(res, n, b, KIND_DATA);
            endcase
            if (beat.last_byte) add_result(res, n, FLAG_END, KIND_DATA);
        end else begin
            case (model_phase)
                IN_FRAME: begin
                    if (b == FLAG_END) begin
                        add_result(res, n, 8'h00, KIND_DONE);
                        model_phase = HUNTING;
                    end else if (b == ESC) begin
                        model_phase = AFTER_ESC;
                    end else begin
                        add_result(res, n, b, KIND_DATA);
                    end
                end
                AFTER_ESC: begin
                    model_phase = IN_FRAME;
                    case (b)
                        ESC_START: add_result(res, n, FLAG_START, KIND_DATA);
                        ESC_ESC:   add_result(res, n, ESC, KIND_DATA);
                        ESC_END:   add_result(res, n, FLAG_END, KIND_DATA);
                        default: begin
                            // bad escape code drops the frame
                            add_result(res, n, 8'h00, KIND_ERR);
                            model_phase = HUNTING;
                        end
                    endcase
                end
                default: model_phase = (b == FLAG_START) ? IN_FRAME : HUNTING;
            endcase
            // buffer end with a frame still open
            if (beat.last_byte && model_phase != HUNTING) begin
                add_result(res, n, 8'h00, KIND_ERR);
                model_phase = HUNTING;
            end
        end
        if (n > 0) res[n-1].last_of_run = 1'b1;
    endfunction

    function automatic void flag_mismatch(input string why, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("cycle %0d %s: expected byte %h kind %0d last %0d, %s",
                     cycles, why, want.out_byte, want.kind, want.last_of_run,
                     $sformatf("got byte %h kind %0d last %0d",
                               got.out_byte, got.kind, got.last_of_run));
    endfunction

    // register writes, accepted beats and delivered results, all in one place
    always @(posedge clk) begin
        t_out [3:0] calc;
        int n;
        t_fixed fx;
        t_out want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                model_dir = cfg_data;
                model_phase = HUNTING;
                dir_writes++;
            end
            if (in_valid && !in_stall) begin
                codec_predict(in_data, calc, n);
                fx = fixed_due.pop_front();
                if (fx.count >= 0) begin
                    calc = fx.res;
                    n = fx.count;
                end
                for (int k = 0; k < n; k++) results_due.push_back(calc[k]);
                beats_in++;
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", '0, out_data);
                end else begin
                    want = results_due.pop_front();
                    if (out_data.out_byte !== want.out_byte || out_data.kind !== want.kind ||
                        out_data.last_of_run !== want.last_of_run)
                        flag_mismatch("wrong result", want, out_data);
                end
            end
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input t_in beat, input int fixed_n = -1,
                             input t_out [3:0] fixed_res = '0);
        t_fixed fx;
        fx.count = fixed_n;
        fx.res = fixed_res;
        fixed_due.push_back(fx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_plain(input logic [7:0] b, input logic l);
        t_in beat;
        beat.in_byte = b;
        beat.first_byte = 1'($urandom_range(1));
        beat.last_byte = l;
        send_beat(beat);
    endtask

    // hold the sender until every expected result has been delivered
    task automatic drain;
        in_valid <= 1'b0;
        // let the checker record the last accepted beat first
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        drain();
        // a beat with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random byte, one in four drawn from the flag and escape codes or FF
    function automatic logic [7:0] pick_byte;
        if ($urandom_range(3) != 0) return 8'($urandom_range(255));
        case ($urandom_range(6))
            0: return FLAG_START;
            1: return FLAG_END;
            2: return ESC;
            3: return ESC_START;
            4: return ESC_END;
            5: return ESC_ESC;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic encode_frame(output int counted);
        t_in beat;
        int len;
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
            beat.in_byte = pick_byte();
            beat.first_byte = (i == 0);
            beat.last_byte = (i == len - 1);
            // now and then stray flags
            if ($urandom_range(7) == 0) begin
                beat.first_byte = 1'($urandom_range(1));
                beat.last_byte = 1'($urandom_range(1));
            end
            send_beat(beat);
        end
        counted = len;
    endtask

    // mostly well-formed line frames, some with a bad escape or a buffer end inside
    task automatic decode_frame(output int counted);
        logic [7:0] raw;
        int len;
        int ending;
        counted = 0;
        // line noise while hunting
        if ($urandom_range(3) == 0) begin
            raw = pick_byte();
            if (raw == FLAG_START) raw = 8'h5A;
            send_plain(raw, 1'($urandom_range(1)));
        end
        send_plain(FLAG_START, 1'b0);
        counted++;
        len = $urandom_range(5);
        for (int i = 0; i < len; i++) begin
            raw = pick_byte();
            if (raw == FLAG_END || raw == ESC || (raw == FLAG_START && $urandom_range(1) == 1))
            begin
                send_plain(ESC, 1'b0);
                send_plain(raw == FLAG_END ? ESC_END : (raw == ESC ? ESC_ESC : ESC_START), 1'b0);
                counted += 2;
            end else begin
                send_plain(raw, 1'b0);
                counted++;
            end
        end
        ending = $urandom_range(9);
        if (ending == 0) begin
            send_plain(ESC, 1'b0);
            raw = 8'($urandom_range(255));
            if (raw == ESC_START || raw == ESC_ESC || raw == ESC_END) raw = FLAG_END;
            send_plain(raw, 1'($urandom_range(1)));
            counted += 2;
        end else if (ending == 1) begin
            send_plain(pick_byte(), 1'b1);
            counted++;
        end else begin
            send_plain(FLAG_END, ($urandom_range(3) == 0));
            counted++;
        end
    endtask

    function automatic void add_row(input logic dir, input logic [7:0] b, input logic f,
                                    input logic l, input int n = -1,
                                    input t_out r0 = '0, input t_out r1 = '0,
                                    input t_out r2 = '0, input t_out r3 = '0);
        t_row row;
        row.dir = dir;
        row.beat.in_byte = b;
        row.beat.first_byte = f;
        row.beat.last_byte = l;
        row.count = n;
        row.res[0] = r0;
        row.res[1] = r1;
        row.res[2] = r2;
        row.res[3] = r3;
        stim_rows.push_back(row);
    endfunction

    initial begin
        logic cur_dir;
        int got;
        int counted;

        // encode: flags, byte extremes and all three escapes
        add_row(DIR_ENCODE, 8'h00, 1'b1, 1'b0, 2, mk_out(FLAG_START, KIND_DATA, 1'b0),
                mk_out(8'h00, KIND_DATA, 1'b1));
        add_row(DIR_ENCODE, 8'hFF, 1'b0, 1'b0, 1, mk_out(8'hFF, KIND_DATA, 1'b1));
        add_row(DIR_ENCODE, FLAG_START, 1'b0, 1'b0, 2, mk_out(ESC, KIND_DATA, 1'b0),
                mk_out(ESC_START, KIND_DATA, 1'b1));
        add_row(DIR_ENCODE, FLAG_END, 1'b0, 1'b0, 2, mk_out(ESC, KIND_DATA, 1'b0),
                mk_out(ESC_END, KIND_DATA, 1'b1));
        add_row(DIR_ENCODE, ESC, 1'b0, 1'b0, 2, mk_out(ESC, KIND_DATA, 1'b0),
                mk_out(ESC_ESC, KIND_DATA, 1'b1));
        add_row(DIR_ENCODE, 8'h55, 1'b0, 1'b1, 2, mk_out(8'h55, KIND_DATA, 1'b0),
                mk_out(FLAG_END, KIND_DATA, 1'b1));
        // single-beat frame with an escaped byte: four results
        add_row(DIR_ENCODE, FLAG_START, 1'b1, 1'b1, 4, mk_out(FLAG_START, KIND_DATA, 1'b0),
                mk_out(ESC, KIND_DATA, 1'b0), mk_out(ESC_START, KIND_DATA, 1'b0),
                mk_out(FLAG_END, KIND_DATA, 1'b1));
        add_row(DIR_ENCODE, 8'hA5, 1'b1, 1'b1);
        // decode: noise while hunting, then a frame with every escape
        add_row(DIR_DECODE, 8'h33, 1'b0, 1'b1, 0);
        add_row(DIR_DECODE, FLAG_START, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, FLAG_START, 1'b1, 1'b0, 1, mk_out(FLAG_START, KIND_DATA, 1'b1));
        add_row(DIR_DECODE, ESC, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, ESC_START, 1'b0, 1'b0, 1, mk_out(FLAG_START, KIND_DATA, 1'b1));
        add_row(DIR_DECODE, ESC, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, ESC_ESC, 1'b0, 1'b0, 1, mk_out(ESC, KIND_DATA, 1'b1));
        add_row(DIR_DECODE, ESC, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, ESC_END, 1'b0, 1'b0, 1, mk_out(FLAG_END, KIND_DATA, 1'b1));
        add_row(DIR_DECODE, FLAG_END, 1'b0, 1'b0, 1, mk_out(8'h00, KIND_DONE, 1'b1));
        // end flag straight after an escape is a bad escape
        add_row(DIR_DECODE, FLAG_START, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, ESC, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, FLAG_END, 1'b0, 1'b0, 1, mk_out(8'h00, KIND_ERR, 1'b1));
        // buffer end on a frame just opened, and after a data byte
        add_row(DIR_DECODE, FLAG_START, 1'b0, 1'b1, 1, mk_out(8'h00, KIND_ERR, 1'b1));
        add_row(DIR_DECODE, FLAG_START, 1'b0, 1'b0, 0);
        add_row(DIR_DECODE, 8'h42, 1'b0, 1'b0);
        add_row(DIR_DECODE, 8'h80, 1'b0, 1'b1, 2, mk_out(8'h80, KIND_DATA, 1'b0),
                mk_out(8'h00, KIND_ERR, 1'b1));

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        cur_dir = DIR_ENCODE;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].dir != cur_dir) begin
                cur_dir = stim_rows[i].dir;
                set_direction(cur_dir);
            end
            send_beat(stim_rows[i].beat, stim_rows[i].count, stim_rows[i].res);
        end

        // random frames, four idling patterns, both directions each
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            for (int d = 0; d < 2; d++) begin
                set_direction(d == 0 ? DIR_ENCODE : DIR_DECODE);
                counted = 0;
                while (counted < 8) begin
                    if (d == 0) encode_frame(got);
                    else decode_frame(got);
                    counted += got;
                    if ($urandom_range(9) == 0) drain();
                end
            end
        end

        // wind down
        drain();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (results_due.size() != 0) begin
            $display("%0d expected results never arrived", results_due.size());
            mismatches++;
        end
        $display("covered %0d input beats and %0d results over %0d direction writes,",
                 beats_in, results_seen, dir_writes);
        $display("encode and decode each under four idling patterns");
        if (mismatches == 0) begin
            $display("byte_stuffing_frame_codec_top_test passed");
        end else begin
            $display("byte_stuffing_frame_codec_top_test failed");
        end
        $finish;
    end

endmodule

>>> byte_stuffing_frame_codec_top.f
src/bfc_pkg.sv
src/bfc_front.sv
src/bfc_queue.sv
src/bfc_back.sv
src/byte_stuffing_frame_codec_top.sv
src/bfc_checker.sv
verif/byte_stuffing_frame_codec_top_test.sv
